### rtl/sacwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sacwt_pkg;
  localparam int MEM_BYTES = 65536;
  localparam int CACHE_BYTES = 4096;
  localparam int BLOCK_BYTES = 64;
  localparam int WAYS = 4;
  localparam int ADDR_BITS = 16;
  localparam int SET_RAW = CACHE_BYTES / (BLOCK_BYTES * WAYS);
  localparam int SET_COUNT = (SET_RAW > 0) ? SET_RAW : 1;
  localparam int LINE_COUNT = SET_COUNT * WAYS;
  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LINE_W = $clog2(LINE_COUNT) > 0 ? $clog2(LINE_COUNT) : 1;
  localparam int MEM_W = $clog2(MEM_BYTES);
  localparam int TAG_RAW = MEM_W - OFF_W - $clog2(SET_COUNT);
  localparam int TAG_W = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int RANK_W = $clog2(WAYS + 1);
  localparam int LDATA_W = $clog2(LINE_COUNT * BLOCK_BYTES);
  localparam logic [7:0] BAD_ADDR_BYTE = 8'd32;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_FILL_RD, ST_FILL, ST_RDHIT, ST_RDOUT, ST_WR, ST_DIV, ST_DONE,
    ST_CLEAR
  } sacwt_state_t;

  typedef struct packed {
    logic latch;
    logic look;
    logic fill_start;
    logic fill_step;
    logic fill_end;
    logic rd_issue;
    logic rd_take;
    logic wr_do;
    logic div_start;
    logic clr_step;
    logic emit;
  } sacwt_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_wr;
    logic hit;
    logic fill_last;
    logic div_done;
    logic clr_last;
  } sacwt_sts_t;
endpackage
`default_nettype wire

### rtl/sacwt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sacwt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  output sacwt_pkg::sacwt_cmd_t      cmd,
  input  wire sacwt_pkg::sacwt_sts_t sts
);
  import sacwt_pkg::*;
  sacwt_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
        if (sts.bad) state_nxt = ST_DIV;
        else if (sts.is_wr) state_nxt = ST_WR;
        else if (sts.hit) state_nxt = ST_RDHIT;
        else begin
          cmd.fill_start = 1'b1;
          state_nxt = ST_FILL_RD;
        end
      end
      ST_FILL_RD: begin
        cmd.fill_step = 1'b1;
        state_nxt = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.fill_end = 1'b1;
          state_nxt = ST_RDHIT;
        end
      end
      ST_RDHIT: begin
        cmd.rd_issue = 1'b1;
        state_nxt = ST_RDOUT;
      end
      ST_RDOUT: begin
        cmd.rd_take = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_WR: begin
        cmd.wr_do = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/sacwt_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module sacwt_dp (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sacwt_pkg::sacwt_cmd_t cmd,
  output sacwt_pkg::sacwt_sts_t      sts,
  input  wire logic                  in_mode,
  input  wire logic [15:0]           in_address,
  input  wire logic [7:0]            in_write_data,
  output logic                       out_valid,
  output logic [7:0]                 out_read_data,
  output logic                       out_hit,
  output logic                       out_addr_error,
  output logic [6:0]                 out_miss_percent
);
  import sacwt_pkg::*;

  logic [7:0] main_mem [MEM_BYTES];
  logic [7:0] line_mem [LINE_COUNT * BLOCK_BYTES];
  logic [TAG_W-1:0] tag_r [WAYS][SET_COUNT];
  logic [LINE_COUNT-1:0] valid_r, dirty_r;
  logic [RANK_W-1:0] rank_r [WAYS][SET_COUNT];

  logic mode_r;
  logic [15:0] addr_r;
  logic [7:0] wdata_r;
  logic [31:0] hits_r, misses_r;

  logic [16:0] addr_x;
  logic bad;
  logic [OFF_W-1:0] off;
  logic [SET_W-1:0] set_idx;
  logic [TAG_W-1:0] tag;
  logic [16:0] blk;

  assign addr_x = {1'b0, addr_r};
  assign bad = addr_x >= 17'(MEM_BYTES);
  assign off = addr_r[OFF_W-1:0];
  assign blk = addr_x >> OFF_W;
  assign set_idx = SET_W'(blk % 17'(SET_COUNT));
  assign tag = TAG_W'(blk / 17'(SET_COUNT));

  logic hit_c;
  logic [WAY_W-1:0] hit_way, vict_way;
  logic [RANK_W-1:0] best_rank;
  logic found_inv;
  always_comb begin
    hit_c = 1'b0;
    hit_way = '0;
    vict_way = '0;
    best_rank = '0;
    found_inv = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_r[LINE_W'(int'(set_idx) * WAYS + w)] &&
          tag_r[w][set_idx] == tag && !hit_c) begin
        hit_c = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!found_inv) begin
        if (!valid_r[LINE_W'(int'(set_idx) * WAYS + w)]) begin
          found_inv = 1'b1;
          vict_way = WAY_W'(w);
        end else if (w == 0 || rank_r[w][set_idx] > best_rank) begin
          best_rank = rank_r[w][set_idx];
          vict_way = WAY_W'(w);
        end
      end
    end
  end

  logic [WAY_W-1:0] way_r;
  logic hit_r;
  logic [LINE_W-1:0] line;
  assign line = LINE_W'(int'(set_idx) * WAYS + int'(way_r));

  // fill sequencing: read pointer leads write pointer by one
  logic [OFF_W:0] fcnt_r, wcnt_r;
  logic [7:0] mrd_r;
  logic [16:0] faddr;
  assign faddr = 17'((int'(blk) * BLOCK_BYTES) + int'(fcnt_r[OFF_W-1:0]));

  logic [15:0] clr_r;
  assign sts.clr_last = clr_r == 16'(MEM_BYTES - 1);
  assign sts.bad = bad;
  assign sts.is_wr = mode_r;
  assign sts.hit = hit_c;
  assign sts.fill_last = wcnt_r == (OFF_W+1)'(BLOCK_BYTES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr_step) clr_r <= clr_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) main_mem[MEM_W'(clr_r)] <= 8'd0;
    else if (cmd.wr_do) main_mem[MEM_W'(addr_r)] <= wdata_r;
    if (faddr < 17'(MEM_BYTES)) mrd_r <= main_mem[MEM_W'(faddr)];
    else mrd_r <= 8'd0;
  end

  logic [7:0] lrd_r;
  always_ff @(posedge clk) begin
    if (cmd.fill_step && fcnt_r != 0)
      line_mem[LDATA_W'(int'(line) * BLOCK_BYTES + int'(wcnt_r[OFF_W-1:0]))] <= mrd_r;
    if (cmd.wr_do && hit_r)
      line_mem[LDATA_W'(int'(line) * BLOCK_BYTES + int'(off))] <= wdata_r;
    lrd_r <= line_mem[LDATA_W'(int'(line) * BLOCK_BYTES + int'(off))];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_start) begin
      fcnt_r <= '0;
      wcnt_r <= '0;
    end else if (cmd.fill_step) begin
      fcnt_r <= fcnt_r + 1'b1;
      if (fcnt_r != 0) wcnt_r <= wcnt_r + 1'b1;
    end
  end

  // request latch; way_r takes the hit way or the victim way
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      addr_r <= in_address;
      wdata_r <= in_write_data;
    end
    if (cmd.look) begin
      hit_r <= hit_c;
      way_r <= hit_c ? hit_way : vict_way;
    end
  end

  // an invalid line counts as rank zero
  logic do_touch;
  assign do_touch = cmd.fill_end || (cmd.wr_do && hit_r);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      dirty_r <= '0;
    end else begin
      if (do_touch) begin
        for (int w = 0; w < WAYS; w++) begin
          if (WAY_W'(w) != way_r && valid_r[LINE_W'(int'(set_idx) * WAYS + w)] &&
              (!valid_r[line] || rank_r[w][set_idx] < rank_r[way_r][set_idx]))
            rank_r[w][set_idx] <= rank_r[w][set_idx] + 1'b1;
        end
        rank_r[way_r][set_idx] <= RANK_W'(1);
      end
      if (cmd.fill_end) begin
        valid_r[line] <= 1'b1;
        dirty_r[line] <= 1'b0;
        tag_r[way_r][set_idx] <= tag;
      end
      if (cmd.wr_do && hit_r) dirty_r[line] <= 1'b1;
    end
  end

  // counters
  logic [31:0] hits_nxt, misses_nxt;
  always_comb begin
    hits_nxt = hits_r;
    misses_nxt = misses_r;
    if (cmd.look && !bad) begin
      if (hit_c) hits_nxt = (hits_r == COUNT_MAX) ? hits_r : hits_r + 32'd1;
      else misses_nxt = (misses_r == COUNT_MAX) ? misses_r : misses_r + 32'd1;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r <= '0;
      misses_r <= '0;
    end else begin
      hits_r <= hits_nxt;
      misses_r <= misses_nxt;
    end
  end

  // restoring divider, one quotient bit per cycle: misses*100 / total
  logic [39:0] num_r;
  logic [32:0] den_r;
  logic [33:0] rem_r;
  logic [6:0] quo_r;
  logic [5:0] dcnt_r;
  logic div_run_r;
  logic [33:0] trial;
  logic div_go;
  assign div_go = cmd.div_start || (cmd.look && bad);
  assign trial = {rem_r[32:0], num_r[39]} - {1'b0, den_r};
  assign sts.div_done = !div_run_r && !div_go;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
    end else if (div_go) begin
      num_r <= misses_r * 40'd100;
      den_r <= {1'b0, hits_r} + {1'b0, misses_r};
      rem_r <= '0;
      quo_r <= '0;
      dcnt_r <= 6'd40;
      div_run_r <= 1'b1;
    end else if (div_run_r) begin
      num_r <= {num_r[38:0], 1'b0};
      if (!trial[33]) begin
        rem_r <= trial;
        quo_r <= {quo_r[5:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], num_r[39]};
        quo_r <= {quo_r[5:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) div_run_r <= 1'b0;
    end
  end

  logic [7:0] rdata_r;
  always_ff @(posedge clk) begin
    if (cmd.look) rdata_r <= bad ? BAD_ADDR_BYTE : 8'd0;
    else if (cmd.rd_take) rdata_r <= lrd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.emit;
    if (cmd.emit) begin
      out_read_data <= rdata_r;
      out_hit <= hit_r && !bad;
      out_addr_error <= bad;
      out_miss_percent <= (den_r == 0) ? 7'd0 : quo_r;
    end
  end
endmodule
`default_nettype wire

### rtl/set_assoc_cache_write_through.sv
// channel  ports                                              direction
// input    start, busy, in_mode, in_address, in_write_data    in (busy out)
// result   out_valid, out_read_data, out_hit, out_addr_error,  out
//          out_miss_percent
// beat to beat, a write or a read hit waits on the 40-step percent divider
// a read miss first copies the block over one memory port
// after reset, busy stays high while main memory is cleared
// out_valid is high for one cycle per item; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_cache_write_through (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_mode,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_write_data,
  output logic             out_valid,
  output logic [7:0]       out_read_data,
  output logic             out_hit,
  output logic             out_addr_error,
  output logic [6:0]       out_miss_percent
);
  import sacwt_pkg::*;
  sacwt_cmd_t cmd;
  sacwt_sts_t sts;

  sacwt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  sacwt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_address(in_address), .in_write_data(in_write_data),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_hit(out_hit),
    .out_addr_error(out_addr_error), .out_miss_percent(out_miss_percent)
  );

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_miss_percent <= 7'd100) else $error("miss percent out of range");
  a_err_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_addr_error |-> !out_hit && out_read_data == BAD_ADDR_BYTE)
    else $error("bad address result wrong");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after beat");
endmodule
`default_nettype wire

### test/cache_checker.sv
`timescale 1ns / 1ps
module cache_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic        out_valid,
  input  logic [7:0]  out_read_data,
  input  logic        out_hit,
  input  logic        out_addr_error,
  input  logic [6:0]  out_miss_percent,
  output int          mismatches,
  output int          pending
);
  import sacwt_pkg::*;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hit;
    logic       addr_error;
    logic [6:0] miss_percent;
  } access_result_t;

  logic [7:0]  backing_mem [MEM_BYTES];
  logic [7:0]  cached_byte [LINE_COUNT * BLOCK_BYTES];
  int unsigned cached_tag  [LINE_COUNT];
  logic        cached_ok   [LINE_COUNT];
  logic [7:0]  age_rank    [LINE_COUNT];
  logic [31:0] hits;
  logic [31:0] misses;
  access_result_t expected_q [$];

  initial begin
    mismatches = 0;
    hits = '0;
    misses = '0;
    foreach (backing_mem[i]) backing_mem[i] = '0;
    foreach (cached_byte[i]) cached_byte[i] = '0;
    foreach (cached_ok[i]) begin
      cached_ok[i] = 1'b0;
      age_rank[i] = '0;
      cached_tag[i] = 0;
    end
  end

  assign pending = expected_q.size();

  task automatic report(input string field, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  function automatic void make_youngest(input int set, input int ln);
    logic [7:0] old;
    int o;
    old = age_rank[ln];
    for (int w = 0; w < WAYS; w++) begin
      o = set * WAYS + w;
      if (o != ln && age_rank[o] != 0 && (old == 0 || age_rank[o] < old))
        age_rank[o]++;
    end
    age_rank[ln] = 1;
  endfunction

  function automatic int choose_way(input int set);
    int best;
    int ln;
    best = set * WAYS;
    for (int w = 0; w < WAYS; w++) begin
      ln = set * WAYS + w;
      if (!cached_ok[ln]) return ln;
      if (age_rank[ln] > age_rank[best]) best = ln;
    end
    return best;
  endfunction

  function automatic access_result_t cache_access(input logic wr, input logic [15:0] addr,
                                                  input logic [7:0] wdata);
    access_result_t r;
    int blk, off, set, tag, ln, a;
    logic [63:0] total;
    r = '0;
    if (int'(addr) >= MEM_BYTES) begin
      r.read_data = BAD_ADDR_BYTE;
      r.addr_error = 1'b1;
    end else begin
      blk = addr / BLOCK_BYTES;
      off = addr % BLOCK_BYTES;
      set = blk % SET_COUNT;
      tag = blk / SET_COUNT;
      ln = -1;
      for (int w = 0; w < WAYS; w++)
        if (ln < 0 && cached_ok[set * WAYS + w] && cached_tag[set * WAYS + w] == tag)
          ln = set * WAYS + w;
      if (ln >= 0) begin
        if (hits != COUNT_MAX) hits++;
        r.hit = 1'b1;
      end else if (misses != COUNT_MAX) misses++;
      if (!wr) begin
        if (ln < 0) begin
          ln = choose_way(set);
          for (int i = 0; i < BLOCK_BYTES; i++) begin
            a = blk * BLOCK_BYTES + i;
            cached_byte[ln * BLOCK_BYTES + i] = (a < MEM_BYTES) ? backing_mem[a] : 8'd0;
          end
          make_youngest(set, ln);
          cached_tag[ln] = tag;
          cached_ok[ln] = 1'b1;
        end
        r.read_data = cached_byte[ln * BLOCK_BYTES + off];
      end else begin
        if (ln >= 0) begin
          cached_byte[ln * BLOCK_BYTES + off] = wdata;
          make_youngest(set, ln);
        end
        backing_mem[addr] = wdata;
      end
    end
    total = 64'(hits) + 64'(misses);
    r.miss_percent = (total == 0) ? 7'd0 : 7'((64'(misses) * 100) / total);
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && start && !busy)
      expected_q.push_back(cache_access(in_mode, in_address, in_write_data));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report("unexpected result beat", 1, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_read_data !== want.read_data) report("read_data", out_read_data, want.read_data);
        if (out_hit !== want.hit) report("hit", out_hit, want.hit);
        if (out_addr_error !== want.addr_error)
          report("addr_error", out_addr_error, want.addr_error);
        if (out_miss_percent !== want.miss_percent)
          report("miss_percent", out_miss_percent, want.miss_percent);
      end
    end
  end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import sacwt_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int RANDOM_ITEMS = 1680;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = 1'b0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic [7:0]  out_read_data;
  logic        out_hit;
  logic        out_addr_error;
  logic [6:0]  out_miss_percent;
  int          mismatches;
  int          pending;
  int          cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  set_assoc_cache_write_through dut (.*);

  cache_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send(input logic wr, input logic [15:0] addr, input logic [7:0] wdata);
    start <= 1'b1;
    in_mode <= wr;
    in_address <= addr;
    in_write_data <= wdata;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  task automatic pause(input int n);
    start <= 1'b0;
    in_mode <= 1'($urandom);
    in_address <= 16'($urandom);
    repeat (n) @(posedge clk);
  endtask

  // most addresses built from tag, set and byte offset so sets see heavy reuse
  function automatic logic [15:0] pick_address();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 16'($urandom);
    return 16'(($urandom_range(0, 7) * SET_COUNT + $urandom_range(0, 2)) * BLOCK_BYTES
               + $urandom_range(0, BLOCK_BYTES - 1));
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, write miss, read fill, write hit, eviction
    send(1'b0, 16'h0000, 8'h00);
    send(1'b0, 16'hFFFF, 8'hFF);
    send(1'b1, 16'h0001, 8'hFF);
    send(1'b0, 16'h0001, 8'h00);
    send(1'b1, 16'h0002, 8'hA5);
    send(1'b0, 16'h0002, 8'h00);
    send(1'b1, 16'hFFFF, 8'h5A);
    send(1'b0, 16'hFFFF, 8'h00);
    send(1'b1, 16'h4000, 8'h3C);
    for (int t = 0; t < 6; t++)
      send(1'b0, 16'(t * SET_COUNT * BLOCK_BYTES + t), 8'h00);
    send(1'b1, 16'(5 * SET_COUNT * BLOCK_BYTES), 8'h77);
    send(1'b0, 16'h0000, 8'h00);
    send(1'b0, 16'(5 * SET_COUNT * BLOCK_BYTES), 8'h00);
    send(1'b0, 16'(2 * SET_COUNT * BLOCK_BYTES), 8'h00);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i < RANDOM_ITEMS - 200 && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 19));
      send($urandom_range(0, 2) == 0, pick_address(), 8'($urandom));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sacwt_pkg.sv
rtl/sacwt_ctrl.sv
rtl/sacwt_dp.sv
rtl/set_assoc_cache_write_through.sv
test/cache_checker.sv
test/testbench.sv
